// ===== src/phbcs_pkg.sv =====
// Package for the host-bridge configuration space with SMRAM control.
// Holds the transfer payload types, command codes, fixed ID words and reset defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package phbcs_pkg;

    localparam int NUM_REGS = 44;
    localparam int REG_AW = $clog2(NUM_REGS);

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_PIN   = 2'd2;

    localparam logic [31:0] ID_WORD    = 32'h7100_8086;
    localparam logic [31:0] CLASS_WORD = 32'h0600_0001;
    localparam logic [31:0] TSEG_BASE  = 32'h1000_0000;
    localparam logic [31:0] TSEG_UNIT  = 32'h0002_0000;
    localparam logic [7:0]  REG_BASE   = 8'h50;

    localparam logic [7:0] OFF_ID    = 8'h00;
    localparam logic [7:0] OFF_CLASS = 8'h08;
    localparam logic [7:0] OFF_CAP   = 8'h34;
    localparam logic [7:0] OFF_RSVD  = 8'h38;

    localparam logic [REG_AW-1:0] SMRAM_IDX = REG_AW'(8);

    localparam logic [28:0] MEM_SIZE_RESET = 29'd16777216;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  function_number;
        logic [7:0]  byte_offset;
        logic [31:0] write_data;
        logic [3:0]  byte_enable;
        logic        smi_active;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        bad_offset;
        logic [2:0]  smram_mapping;
        logic        mapping_changed;
        logic [31:0] tseg_start;
    } out_item_t;

    typedef struct packed {
        logic              word_we;
        logic [REG_AW-1:0] word_idx;
        logic [31:0]       word_data;
        logic              smram_we;
        logic              smi_we;
        logic              smi_n;
        logic [2:0]        mapping;
    } state_upd_t;

    function automatic logic [31:0] reg_default(input logic [REG_AW-1:0] idx);
        logic [31:0] v;
        case (idx)
            REG_AW'(0): v = 32'h1402_0000;
            REG_AW'(1): v = 32'h0152_0000;
            REG_AW'(4): v = 32'h0202_0202;
            REG_AW'(5): v = 32'h0000_0002;
            default:    v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/pci_host_bridge_config_smram_core.sv =====
// Top level of the host-bridge configuration space with SMRAM control.
// Depends on phbcs_pkg, phbcs_ram and phbcs_exec.
`timescale 1ns / 1ps
`default_nettype none

// One configuration read, configuration write or SMIACT pin change is taken per
// cycle while s_ready is high. The input transfer registers the item and the
// register-file RAM read; when the item advances, the read-modify-write is
// done and the result register loaded. A result held by m_ready stalls the item
// register, and s_ready drops only while both the item register and the result
// register are full. A write followed directly by an access to the same word is
// forwarded. The 44-word register file sits in a RAM; per-word valid bits,
// cleared by reset, make never-written words read as their defaults, so no
// clearing pass is needed. The user must write the installed DRAM size on the cfg
// port only while the block is idle; the block itself does not enforce this.
module pci_host_bridge_config_smram_core (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire phbcs_pkg::in_item_t   s_item,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output phbcs_pkg::out_item_t       m_item,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [28:0]           cfg_data
);
    import phbcs_pkg::*;

    logic              stg_valid_reg;
    in_item_t          stg_item_reg;
    logic              byp_sel_reg;
    logic [31:0]       byp_data_reg;
    logic              byp_sel_next;
    logic [31:0]       byp_data_next;
    logic [31:0]       ram_rdata;
    logic [31:0]       word;
    logic              out_valid_reg;
    out_item_t         out_item_reg;
    logic [NUM_REGS-1:0] ent_valid_reg;
    logic [31:0]       smram_reg;
    logic              smi_n_reg;
    logic [2:0]        map_reg;
    logic [28:0]       mem_size_reg;
    out_item_t         result;
    state_upd_t        upd;
    logic              advance;
    logic              accept;
    logic              acc_in_file;
    logic [REG_AW-1:0] acc_addr;
    logic              hit;

    assign advance   = stg_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !stg_valid_reg || advance;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;

    assign acc_in_file = (s_item.byte_offset >= REG_BASE);
    assign acc_addr    = acc_in_file ?
                         REG_AW'(s_item.byte_offset[7:2] - REG_BASE[7:2]) : '0;

    always_comb begin
        hit           = advance && upd.word_we && (upd.word_idx == acc_addr);
        byp_sel_next  = hit || !ent_valid_reg[acc_addr];
        byp_data_next = hit ? upd.word_data : reg_default(acc_addr);
    end

    assign word = byp_sel_reg ? byp_data_reg : ram_rdata;

    phbcs_ram #(
        .WIDTH(32),
        .DEPTH(NUM_REGS)
    ) u_regfile (
        .aclk  (aclk),
        .we    (advance && upd.word_we),
        .waddr (upd.word_idx),
        .wdata (upd.word_data),
        .re    (accept),
        .raddr (acc_addr),
        .rdata (ram_rdata)
    );

    phbcs_exec u_exec (
        .item      (stg_item_reg),
        .word      (word),
        .smram_q   (smram_reg),
        .smi_n_q   (smi_n_reg),
        .map_q     (map_reg),
        .mem_size  (mem_size_reg),
        .result    (result),
        .upd       (upd)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_item_reg <= s_item;
            byp_sel_reg  <= byp_sel_next;
            byp_data_reg <= byp_data_next;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            ent_valid_reg <= '0;
            smram_reg     <= 32'h0;
            smi_n_reg     <= 1'b1;
            map_reg       <= 3'd0;
            mem_size_reg  <= MEM_SIZE_RESET;
        end else begin
            if (accept) begin
                stg_valid_reg <= 1'b1;
            end else if (advance) begin
                stg_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                if (upd.word_we) begin
                    ent_valid_reg[upd.word_idx] <= 1'b1;
                end
                if (upd.smram_we) begin
                    smram_reg <= upd.word_data;
                end
                if (upd.smi_we) begin
                    smi_n_reg <= upd.smi_n;
                end
                map_reg <= upd.mapping;
            end
            if (cfg_valid && cfg_ready) begin
                mem_size_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/phbcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module phbcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 44
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/phbcs_exec.sv =====
// Per-item execute logic: offset decode, read mux, masked write merge,
// SMRAM mapping and TSEG start. Depends on phbcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module phbcs_exec (
    input  wire phbcs_pkg::in_item_t   item,
    input  wire logic [31:0]           word,
    input  wire logic [31:0]           smram_q,
    input  wire logic                  smi_n_q,
    input  wire logic [2:0]            map_q,
    input  wire logic [28:0]           mem_size,
    output phbcs_pkg::out_item_t       result,
    output phbcs_pkg::state_upd_t      upd
);
    import phbcs_pkg::*;

    function automatic logic [2:0] derive_map(input logic [31:0] r, input logic smi_n);
        logic [2:0] m;
        if (!r[19] || (smi_n && !r[22])) begin
            m = 3'd0;
        end else begin
            m = {r[8], r[15], !r[15]};
        end
        return m;
    endfunction

    logic [7:0]        off;
    logic              aligned;
    logic              in_file;
    logic [REG_AW-1:0] idx;
    logic              fn0;
    logic              is_read;
    logic              is_write;
    logic              is_pin;
    logic              bad;
    logic [31:0]       rd;
    logic [31:0]       mask;
    logic [31:0]       data;
    logic [31:0]       merged;
    logic              word_we;
    logic              smram_we;
    logic [31:0]       smram_new;
    logic              smi_n_new;
    logic [2:0]        map_new;

    always_comb begin
        off      = item.byte_offset;
        aligned  = (off[1:0] == 2'b00);
        in_file  = (off >= REG_BASE);
        idx      = REG_AW'(off[7:2] - REG_BASE[7:2]);
        fn0      = (item.function_number == 3'd0);
        is_read  = (item.command == CMD_READ) && fn0;
        is_write = (item.command == CMD_WRITE) && fn0;
        is_pin   = (item.command == CMD_PIN);

        bad = (is_read && !aligned) ||
              (is_write && (!aligned || off == OFF_CLASS || off == OFF_CAP ||
                            off == OFF_RSVD));

        rd = 32'h0;
        if (is_read && aligned) begin
            if (off == OFF_ID) begin
                rd = ID_WORD;
            end else if (off == OFF_CLASS) begin
                rd = CLASS_WORD;
            end else if (in_file) begin
                rd = word;
            end
        end

        for (int i = 0; i < 4; i++) begin
            mask[8*i +: 8] = {8{item.byte_enable[i]}};
        end

        // error bit is write-1-to-clear, lock bit is sticky
        data = item.write_data;
        if (idx == SMRAM_IDX) begin
            if (item.byte_enable[1]) begin
                data[14] = word[14] & ~item.write_data[14];
            end
            if (item.byte_enable[2]) begin
                data[20] = item.write_data[20] | word[20];
            end
        end
        merged = (word & ~mask) | (data & mask);

        word_we   = is_write && !bad && in_file;
        smram_we  = word_we && (idx == SMRAM_IDX);
        smram_new = smram_we ? merged : smram_q;
        smi_n_new = is_pin ? !item.smi_active : smi_n_q;
        map_new   = (smram_we || is_pin) ? derive_map(smram_new, smi_n_new) : map_q;

        upd.word_we   = word_we;
        upd.word_idx  = idx;
        upd.word_data = merged;
        upd.smram_we  = smram_we;
        upd.smi_we    = is_pin;
        upd.smi_n     = smi_n_new;
        upd.mapping   = map_new;

        result.read_data       = rd;
        result.bad_offset      = bad;
        result.smram_mapping   = map_new;
        result.mapping_changed = (map_new != map_q);
        result.tseg_start      = TSEG_BASE + {3'b000, mem_size}
                                 - (TSEG_UNIT << smram_new[10:9]);
    end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for pci_host_bridge_config_smram_core: directed and random config
// accesses and SMIACT pin changes, checked against an in-bench predictor.
// Depends on phbcs_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
    import phbcs_pkg::*;

    localparam logic [1:0]  CMD_NONE    = 2'd3;
    localparam logic [7:0]  OFF_SMRAM   = 8'h70;
    localparam logic [31:0] RESET_TSEG  = 32'h10FE_0000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          CYCLE_LIMIT = 500000;
    localparam int          MAX_REPORTS = 10;

    typedef struct {
        logic      pinned;
        out_item_t result;
    } pinned_result_t;

    typedef struct {
        in_item_t  item;
        logic      pinned;
        out_item_t result;
    } directed_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [28:0] cfg_data;

    // predictor state
    logic [31:0] regfile_model [NUM_REGS];
    logic        smi_n_model;
    logic [2:0]  map_model;
    logic [28:0] dram_model;

    out_item_t      expected_results [$];
    pinned_result_t pinned_results [$];
    directed_row_t  directed_rows [$];

    int send_idle_pct;
    int stall_pct;
    int fail_count;
    int cycle_count;
    int hold_count;
    logic pressure_go;

    pci_host_bridge_config_smram_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [2:0] smram_map(logic [31:0] ctl, logic smi_n);
        if (!ctl[19] || (smi_n && !ctl[22])) begin
            return 3'd0;
        end
        return {ctl[8], ctl[15], ~ctl[15]};
    endfunction

    function automatic out_item_t cfg_space_result(in_item_t it);
        out_item_t   r;
        logic [2:0]  prior_map;
        logic [5:0]  idx;
        logic [31:0] data;
        logic [31:0] prev;
        logic [31:0] lanes;
        logic [7:0]  off;
        logic [1:0]  code;
        r = '0;
        prior_map = map_model;
        off = it.byte_offset;
        data = it.write_data;
        idx = 6'((off - REG_BASE) >> 2);
        if (it.command == CMD_READ && it.function_number == 3'd0) begin
            if (off[1:0] != 2'b00) begin
                r.bad_offset = 1'b1;
            end else if (off == OFF_ID) begin
                r.read_data = ID_WORD;
            end else if (off == OFF_CLASS) begin
                r.read_data = CLASS_WORD;
            end else if (off >= REG_BASE) begin
                r.read_data = regfile_model[idx];
            end
        end else if (it.command == CMD_WRITE && it.function_number == 3'd0) begin
            if (off[1:0] != 2'b00 || off == OFF_CLASS || off == OFF_CAP || off == OFF_RSVD) begin
                r.bad_offset = 1'b1;
            end else if (off >= REG_BASE) begin
                prev = regfile_model[idx];
                lanes = {{8{it.byte_enable[3]}}, {8{it.byte_enable[2]}},
                         {8{it.byte_enable[1]}}, {8{it.byte_enable[0]}}};
                if (idx == SMRAM_IDX) begin
                    // error bit is write-one-to-clear, lock bit is sticky
                    if (it.byte_enable[1]) begin
                        data[14] = prev[14] & ~data[14];
                    end
                    if (it.byte_enable[2]) begin
                        data[20] = data[20] | prev[20];
                    end
                end
                regfile_model[idx] = (prev & ~lanes) | (data & lanes);
                if (idx == SMRAM_IDX) begin
                    map_model = smram_map(regfile_model[SMRAM_IDX], smi_n_model);
                end
            end
        end else if (it.command == CMD_PIN) begin
            smi_n_model = ~it.smi_active;
            map_model = smram_map(regfile_model[SMRAM_IDX], smi_n_model);
        end
        code = regfile_model[SMRAM_IDX][10:9];
        r.smram_mapping = map_model;
        r.mapping_changed = (map_model != prior_map);
        r.tseg_start = TSEG_BASE + {3'b000, dram_model} - (TSEG_UNIT << code);
        return r;
    endfunction

    function automatic in_item_t access(logic [1:0] cmd, logic [2:0] fn, logic [7:0] off,
                                        logic [31:0] data, logic [3:0] be, logic smi);
        in_item_t it;
        it.command = cmd;
        it.function_number = fn;
        it.byte_offset = off;
        it.write_data = data;
        it.byte_enable = be;
        it.smi_active = smi;
        return it;
    endfunction

    function automatic out_item_t fixed(logic [31:0] rd, logic bad);
        out_item_t r;
        r = '0;
        r.read_data = rd;
        r.bad_offset = bad;
        r.tseg_start = RESET_TSEG;
        return r;
    endfunction

    function automatic in_item_t random_access();
        in_item_t it;
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) begin
            it.command = CMD_READ;
        end else if (sel < 75) begin
            it.command = CMD_WRITE;
        end else if (sel < 93) begin
            it.command = CMD_PIN;
        end else begin
            it.command = 2'($urandom_range(3, 0));
        end
        it.function_number = ($urandom_range(99) < 88) ? 3'd0 : 3'($urandom_range(7, 0));
        sel = $urandom_range(99);
        if (sel < 30) begin
            it.byte_offset = OFF_SMRAM;
        end else if (sel < 65) begin
            it.byte_offset = {6'($urandom_range(63, 20)), 2'b00};
        end else if (sel < 90) begin
            it.byte_offset = {6'($urandom_range(63, 0)), 2'b00};
        end else begin
            it.byte_offset = 8'($urandom_range(255, 0));
        end
        it.write_data = $urandom;
        it.byte_enable = ($urandom_range(1) != 0) ? 4'hF : 4'($urandom_range(15, 0));
        it.smi_active = 1'($urandom_range(1, 0));
        return it;
    endfunction

    task automatic add_row(in_item_t it, logic pinned, out_item_t result);
        directed_row_t row;
        row.item = it;
        row.pinned = pinned;
        row.result = result;
        directed_rows.push_back(row);
    endtask

    task automatic offer(in_item_t it, logic pinned, out_item_t result);
        pinned_result_t p;
        p.pinned = pinned;
        p.result = result;
        pinned_results.push_back(p);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic set_dram_size(logic [28:0] v);
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        dram_model = v;
    endtask

    task automatic run_phase(int send_pct, int stall, logic [28:0] dram, int count);
        set_dram_size(dram);
        send_idle_pct = send_pct;
        stall_pct = stall;
        repeat (count) offer(random_access(), 1'b0, '0);
        s_valid <= 1'b0;
    endtask

    task automatic report(string what, out_item_t want, out_item_t got);
        if (fail_count < MAX_REPORTS) begin
            $display("%0t %s: exp rd=%h bad=%b map=%0d chg=%b tseg=%h", $realtime, what,
                     want.read_data, want.bad_offset, want.smram_mapping,
                     want.mapping_changed, want.tseg_start);
            $display("%0t %s: got rd=%h bad=%b map=%0d chg=%b tseg=%h", $realtime, what,
                     got.read_data, got.bad_offset, got.smram_mapping,
                     got.mapping_changed, got.tseg_start);
        end
        fail_count++;
    endtask

    // scoreboard: compare first, then queue the prediction for this edge's input transfer
    always @(posedge aclk) begin
        out_item_t      want;
        pinned_result_t pin;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected transfer", '0, m_item);
                end else begin
                    want = expected_results.pop_front();
                    if (m_item.read_data !== want.read_data ||
                        m_item.bad_offset !== want.bad_offset ||
                        m_item.smram_mapping !== want.smram_mapping ||
                        m_item.mapping_changed !== want.mapping_changed ||
                        m_item.tseg_start !== want.tseg_start) begin
                        report("mismatch", want, m_item);
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = cfg_space_result(s_item);
                if (pinned_results.size() != 0) begin
                    pin = pinned_results.pop_front();
                    if (pin.pinned) begin
                        want = pin.result;
                    end
                end
                expected_results.push_back(want);
            end
        end
    end

    // the long hold counts only cycles in which the sender is offering
    always @(posedge aclk) begin
        if (pressure_go && s_valid && hold_count < HOLD_CYCLES) begin
            m_ready <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        s_valid = 1'b0;
        s_item = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        aresetn = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        fail_count = 0;
        cycle_count = 0;
        hold_count = 0;
        pressure_go = 1'b0;
        for (int i = 0; i < NUM_REGS; i++) begin
            regfile_model[i] = '0;
        end
        regfile_model[0] = 32'h1402_0000;
        regfile_model[1] = 32'h0152_0000;
        regfile_model[4] = 32'h0202_0202;
        regfile_model[5] = 32'h0000_0002;
        smi_n_model = 1'b1;
        map_model = 3'd0;
        dram_model = MEM_SIZE_RESET;

        add_row(access(CMD_READ, 3'd0, OFF_ID, '0, 4'h0, 1'b0), 1'b1, fixed(ID_WORD, 1'b0));
        add_row(access(CMD_READ, 3'd0, OFF_CLASS, '0, 4'h0, 1'b0), 1'b1,
                fixed(CLASS_WORD, 1'b0));
        add_row(access(CMD_READ, 3'd0, 8'h04, '0, 4'h0, 1'b0), 1'b1, fixed('0, 1'b0));
        add_row(access(CMD_READ, 3'd0, 8'h4C, '0, 4'h0, 1'b0), 1'b1, fixed('0, 1'b0));
        add_row(access(CMD_READ, 3'd0, REG_BASE, '0, 4'h0, 1'b0), 1'b1,
                fixed(32'h1402_0000, 1'b0));
        add_row(access(CMD_READ, 3'd0, 8'hFC, '0, 4'hF, 1'b1), 1'b1, fixed('0, 1'b0));
        add_row(access(CMD_READ, 3'd0, 8'hFF, '1, 4'hF, 1'b1), 1'b1, fixed('0, 1'b1));
        add_row(access(CMD_READ, 3'd7, REG_BASE, '0, 4'h0, 1'b0), 1'b1, fixed('0, 1'b0));
        add_row(access(CMD_WRITE, 3'd0, OFF_CLASS, '1, 4'hF, 1'b0), 1'b1, fixed('0, 1'b1));
        add_row(access(CMD_WRITE, 3'd0, OFF_CAP, '1, 4'hF, 1'b0), 1'b1, fixed('0, 1'b1));
        add_row(access(CMD_WRITE, 3'd0, OFF_RSVD, '1, 4'hF, 1'b0), 1'b1, fixed('0, 1'b1));
        add_row(access(CMD_WRITE, 3'd0, OFF_ID, '1, 4'hF, 1'b0), 1'b1, fixed('0, 1'b0));
        add_row(access(CMD_WRITE, 3'd0, 8'h3C, '1, 4'hF, 1'b0), 1'b1, fixed('0, 1'b0));
        add_row(access(CMD_WRITE, 3'd0, 8'h51, '1, 4'hF, 1'b0), 1'b1, fixed('0, 1'b1));
        add_row(access(CMD_NONE, 3'd7, 8'hFF, '1, 4'hF, 1'b1), 1'b1, fixed('0, 1'b0));
        add_row(access(CMD_PIN, 3'd0, 8'h00, '0, 4'h0, 1'b1), 1'b1, fixed('0, 1'b0));
        add_row(access(CMD_WRITE, 3'd0, OFF_SMRAM, '1, 4'hF, 1'b0), 1'b0, '0);
        add_row(access(CMD_READ, 3'd0, OFF_SMRAM, '0, 4'h0, 1'b0), 1'b0, '0);
        add_row(access(CMD_WRITE, 3'd0, OFF_SMRAM, '0, 4'hF, 1'b0), 1'b0, '0);
        add_row(access(CMD_WRITE, 3'd0, OFF_SMRAM, 32'h0008_8100, 4'h6, 1'b0), 1'b0, '0);
        add_row(access(CMD_PIN, 3'd5, 8'h00, '0, 4'h0, 1'b0), 1'b0, '0);
        add_row(access(CMD_WRITE, 3'd0, OFF_SMRAM, 32'h0040_0000, 4'h4, 1'b0), 1'b0, '0);
        add_row(access(CMD_WRITE, 3'd0, 8'h74, 32'hA5A5_A5A5, 4'h5, 1'b0), 1'b0, '0);
        add_row(access(CMD_READ, 3'd0, 8'h74, '0, 4'h0, 1'b0), 1'b0, '0);
        add_row(access(CMD_WRITE, 3'd3, 8'h5C, '1, 4'hF, 1'b0), 1'b0, '0);
        add_row(access(CMD_WRITE, 3'd0, 8'h58, 32'h1234_5678, 4'hF, 1'b0), 1'b0, '0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            offer(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].result);
        end
        s_valid <= 1'b0;

        // receiver holds off early in this phase so the core backs up
        pressure_go = 1'b1;
        run_phase(0, 0, 29'd1048576, 350);
        run_phase(56, 0, 29'd268435456, 330);
        run_phase(0, 56, 29'($urandom_range(268435456, 1048576)), 330);
        run_phase(13, 13, MEM_SIZE_RESET, 320);

        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
